FILE: design/stb_pkg.sv
package stb_pkg;

   localparam int SLOT_W = 4;
   localparam int SLOT_COUNT = 2 ** SLOT_W;
   localparam int MAX_FIRES = 16;
   localparam int FCNT_W = 5;
   localparam int TIME_W = 32;
   localparam int TAG_W = 8;

   typedef enum logic [2:0] {
      REQ_ALLOC  = 3'd0,
      REQ_FREE   = 3'd1,
      REQ_ARM    = 3'd2,
      REQ_CANCEL = 3'd3,
      REQ_TICK   = 3'd4
   } code_type;

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_BAD_SLOT = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   typedef struct packed {
      code_type            code;
      logic [SLOT_W-1:0]   slot_index;
      logic [TIME_W-1:0]   timeout_ms;
      logic [TAG_W-1:0]    user_tag;
      logic [TIME_W-1:0]   elapsed_ms;
   } req_type;

   // token and accumulators that travel down the cell chain
   typedef struct packed {
      logic                scan;
      logic                emit;
      logic                found;
      logic                hit;
      logic                any;
      logic [TIME_W-1:0]   min;
      logic [FCNT_W-1:0]   fcnt;
      logic [SLOT_W-1:0]   slot;
   } wave_type;

   typedef struct packed {
      logic                valid;
      logic [SLOT_W-1:0]   slot;
      logic [TAG_W-1:0]    tag;
      logic                last;
   } emit_type;

endpackage

FILE: design/stb_cell.sv
module stb_cell #(
   parameter int CELL_ID = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  stb_pkg::req_type  req,
   input  stb_pkg::wave_type up_wave,
   output stb_pkg::wave_type dn_wave,
   output stb_pkg::emit_type emit
);

   localparam bit ADDRESSABLE = (CELL_ID < stb_pkg::SLOT_COUNT);

   logic                          alloc_ff, alloc_in;
   logic                          armed_ff, armed_in;
   logic                          pend_ff, pend_in;
   logic [stb_pkg::TIME_W-1:0]    rem_ff, rem_in;
   logic [stb_pkg::TAG_W-1:0]     tag_ff, tag_in;
   stb_pkg::wave_type             wave_ff, wave_in;
   logic                          addr_hit;
   logic                          expire;
   logic [stb_pkg::TIME_W-1:0]    rem_left;

   assign addr_hit = ADDRESSABLE && (req.slot_index == stb_pkg::SLOT_W'(CELL_ID));
   assign expire   = (rem_ff <= req.elapsed_ms);
   assign rem_left = rem_ff - req.elapsed_ms;
   assign dn_wave  = wave_ff;

   always_comb begin
      alloc_in = alloc_ff;
      armed_in = armed_ff;
      pend_in  = pend_ff;
      rem_in   = rem_ff;
      tag_in   = tag_ff;
      wave_in  = up_wave;
      emit     = '0;
      if (up_wave.scan) begin
         case (req.code)
            stb_pkg::REQ_ALLOC: begin
               // claim only if no lower cell took the request
               if (!up_wave.found && !alloc_ff) begin
                  alloc_in      = 1'b1;
                  wave_in.found = 1'b1;
                  wave_in.slot  = stb_pkg::SLOT_W'(CELL_ID);
               end
            end
            stb_pkg::REQ_FREE: begin
               if (addr_hit && alloc_ff) begin
                  alloc_in    = 1'b0;
                  wave_in.hit = 1'b1;
               end
            end
            stb_pkg::REQ_ARM: begin
               if (addr_hit && alloc_ff) begin
                  armed_in    = 1'b1;
                  rem_in      = req.timeout_ms;
                  tag_in      = req.user_tag;
                  wave_in.hit = 1'b1;
               end
            end
            stb_pkg::REQ_CANCEL: begin
               if (addr_hit && alloc_ff) begin
                  armed_in    = 1'b0;
                  rem_in      = '0;
                  tag_in      = '0;
                  wave_in.hit = 1'b1;
               end
            end
            stb_pkg::REQ_TICK: begin
               if (armed_ff) begin
                  if (expire) begin
                     rem_in = '0;
                     // past the expiry limit: stay armed at zero for the next tick
                     if (up_wave.fcnt < stb_pkg::FCNT_W'(stb_pkg::MAX_FIRES)) begin
                        armed_in     = 1'b0;
                        pend_in      = 1'b1;
                        wave_in.fcnt = up_wave.fcnt + 1'b1;
                     end
                  end else begin
                     rem_in = rem_left;
                  end
               end
            end
            default: begin
            end
         endcase
         // fold this cell's updated time into the running minimum
         if (alloc_in && armed_in && (!up_wave.any || (rem_in < up_wave.min))) begin
            wave_in.min = rem_in;
            wave_in.any = 1'b1;
         end
      end
      if (up_wave.emit && pend_ff) begin
         emit.valid   = 1'b1;
         emit.slot    = stb_pkg::SLOT_W'(CELL_ID);
         emit.tag     = tag_ff;
         emit.last    = (up_wave.fcnt == stb_pkg::FCNT_W'(1));
         pend_in      = 1'b0;
         tag_in       = '0;
         wave_in.fcnt = up_wave.fcnt - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff <= 1'b0;
         armed_ff <= 1'b0;
         pend_ff  <= 1'b0;
         rem_ff   <= '0;
         tag_ff   <= '0;
         wave_ff  <= '0;
      end else begin
         alloc_ff <= alloc_in;
         armed_ff <= armed_in;
         pend_ff  <= pend_in;
         rem_ff   <= rem_in;
         tag_ff   <= tag_in;
         wave_ff  <= wave_in;
      end
   end

endmodule

FILE: design/software_timer_bank.sv
// Operation: a request's word leaves rsp_ once start is taken and the request has walked the
// cell chain; a tick that fires sends its expiry words during a second pass of the chain.
// Flow: a new request is taken only while busy is low, once the one before is through;
// both passes walk the cell chain one slot per cycle.
// Reset: synchronous; all slots come up free, disarmed and at zero; no result pending.
// The receiver cannot stall: each result word is on rsp_ for exactly one cycle.
module software_timer_bank #(
   parameter int NUM_TIMERS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [2:0]                     req_type,
   input  logic [stb_pkg::SLOT_W-1:0]     req_slot_index,
   input  logic [stb_pkg::TIME_W-1:0]     req_timeout_ms,
   input  logic [stb_pkg::TAG_W-1:0]      req_user_tag,
   input  logic [stb_pkg::TIME_W-1:0]     req_elapsed_ms,
   output logic                           rsp_strobe,
   output logic [1:0]                     rsp_status,
   output logic [stb_pkg::SLOT_W-1:0]     rsp_result_slot,
   output logic                           rsp_fired,
   output logic [stb_pkg::TAG_W-1:0]      rsp_fired_tag,
   output logic [stb_pkg::TIME_W-1:0]     rsp_min_wait_ms,
   output logic                           rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT
   } state_type;

   localparam int EMIT_W = $bits(stb_pkg::emit_type);

   state_type                     state_ff, state_in;
   stb_pkg::req_type              req_ff, req_in;
   logic                          launch_scan_ff, launch_scan_in;
   logic                          launch_emit_ff, launch_emit_in;
   logic [stb_pkg::FCNT_W-1:0]    fires_ff, fires_in;
   logic [stb_pkg::TIME_W-1:0]    min_ff, min_in;
   logic                          strobe_ff, strobe_in;
   logic [1:0]                    status_ff, status_in;
   logic [stb_pkg::SLOT_W-1:0]    slot_ff, slot_in;
   logic                          fired_ff, fired_in;
   logic [stb_pkg::TAG_W-1:0]     tag_ff, tag_in;
   logic [stb_pkg::TIME_W-1:0]    wait_ff, wait_in;
   logic                          last_ff, last_in;

   stb_pkg::wave_type             wave [0:NUM_TIMERS];
   stb_pkg::emit_type             cell_emit [0:NUM_TIMERS-1];
   logic [NUM_TIMERS-1:0]         emit_vld;
   logic [EMIT_W-1:0]             emit_or;
   stb_pkg::emit_type             emit_sel;
   stb_pkg::wave_type             tail;
   logic [stb_pkg::TIME_W-1:0]    tail_min;

   always_comb begin
      wave[0]      = '0;
      wave[0].scan = launch_scan_ff;
      wave[0].emit = launch_emit_ff;
      wave[0].fcnt = fires_ff;
   end

   for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
      stb_cell #(
         .CELL_ID (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .req     (req_ff),
         .up_wave (wave[i]),
         .dn_wave (wave[i+1]),
         .emit    (cell_emit[i])
      );
      assign emit_vld[i] = cell_emit[i].valid;
   end

   // only the cell holding the token can drive its word
   always_comb begin
      emit_or = '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         emit_or = emit_or | cell_emit[i];
      end
   end
   assign emit_sel = stb_pkg::emit_type'(emit_or);

   assign tail     = wave[NUM_TIMERS];
   assign tail_min = tail.any ? tail.min : '0;

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      launch_scan_in = 1'b0;
      launch_emit_in = 1'b0;
      fires_in       = fires_ff;
      min_in         = min_ff;
      strobe_in      = 1'b0;
      status_in      = stb_pkg::STATUS_OK;
      slot_in        = '0;
      fired_in       = 1'b0;
      tag_in         = '0;
      wait_in        = tail_min;
      last_in        = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in.code       = stb_pkg::code_type'(req_type);
               req_in.slot_index = req_slot_index;
               req_in.timeout_ms = req_timeout_ms;
               req_in.user_tag   = req_user_tag;
               req_in.elapsed_ms = req_elapsed_ms;
               fires_in          = '0;
               launch_scan_in    = 1'b1;
               state_in          = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail.scan) begin
               if ((req_ff.code == stb_pkg::REQ_TICK) && (tail.fcnt != '0)) begin
                  // hold the minimum and walk the chain again to send the expiries
                  fires_in       = tail.fcnt;
                  min_in         = tail_min;
                  launch_emit_in = 1'b1;
                  state_in       = ST_EMIT;
               end else begin
                  strobe_in = 1'b1;
                  case (req_ff.code)
                     stb_pkg::REQ_ALLOC: begin
                        status_in = tail.found ? stb_pkg::STATUS_OK : stb_pkg::STATUS_FULL;
                        slot_in   = tail.found ? tail.slot : '0;
                     end
                     stb_pkg::REQ_FREE, stb_pkg::REQ_ARM, stb_pkg::REQ_CANCEL: begin
                        status_in = tail.hit ? stb_pkg::STATUS_OK : stb_pkg::STATUS_BAD_SLOT;
                        slot_in   = req_ff.slot_index;
                     end
                     default: begin
                     end
                  endcase
                  fires_in = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_EMIT: begin
            strobe_in = emit_sel.valid;
            slot_in   = emit_sel.slot;
            fired_in  = 1'b1;
            tag_in    = emit_sel.tag;
            wait_in   = min_ff;
            last_in   = emit_sel.last;
            if (tail.emit) begin
               fires_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         launch_scan_ff <= 1'b0;
         launch_emit_ff <= 1'b0;
         fires_ff       <= '0;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         launch_scan_ff <= launch_scan_in;
         launch_emit_ff <= launch_emit_in;
         fires_ff       <= fires_in;
         strobe_ff      <= strobe_in;
      end
      req_ff    <= req_in;
      min_ff    <= min_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      fired_ff  <= fired_in;
      tag_ff    <= tag_in;
      wait_ff   <= wait_in;
      last_ff   <= last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_result_slot = slot_ff;
   assign rsp_fired       = fired_ff;
   assign rsp_fired_tag   = tag_ff;
   assign rsp_min_wait_ms = wait_ff;
   assign rsp_last        = last_ff;

   a_one_emitter: assert property (@(posedge clock) disable iff (reset)
      $onehot0(emit_vld))
      else $error("more than one cell drives an expiry word");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_fire_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_fired) |-> (rsp_status == stb_pkg::STATUS_OK))
      else $error("expiry word carries a failing status");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("word follows the final word of a request");

endmodule
